### rtl/tvb_pkg.sv
// ----------------------------------------------------------------------------
// tvb_pkg
// Shared types, constants and the colour table of the tile video board block.
// ----------------------------------------------------------------------------
package tvb_pkg;

    localparam int PROGRAM_BYTES    = 16384;
    localparam int GRAPHICS_BYTES   = 4096;
    localparam int VISIBLE_LINES    = 208;
    localparam int CLOCKS_PER_FRAME = 45056;
    localparam int VRAM_BYTES       = 8192;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_PIXEL = 3'd2;
    localparam logic [2:0] CMD_LOAD  = 3'd3;
    localparam logic [2:0] CMD_SETIN = 3'd4;

    localparam logic [1:0] REGION_PROGRAM = 2'd0;
    localparam logic [1:0] REGION_BG      = 2'd1;
    localparam logic [1:0] REGION_FG      = 2'd2;

    localparam logic [2:0] REG_DIP_BYTE = 3'd0;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_READ  = 3'd1,
        K_WRITE = 3'd2,
        K_PIXEL = 3'd3,
        K_LOAD  = 3'd4,
        K_SETIN = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [7:0]  data;
        logic [15:0] beam_pos;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [1:0]  rom_region;
    } t_item;

    typedef struct packed {
        logic clearing;
        logic take;
    } t_back_stat;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        sound_valid;
        logic        sound_channel;
        logic [7:0]  sound_data;
        logic [23:0] pixel_rgb;
        logic [7:0]  screen_x;
        logic [7:0]  screen_y;
    } t_result;

    localparam logic [23:0] COLOR_TABLE [128] = '{
        24'h000000, 24'h0a07bd, 24'h9f1114, 24'hc8c8c8,
        24'h000000, 24'h2db8e0, 24'hd11eaa, 24'hedc63a,
        24'h000000, 24'hcdf040, 24'ha71bce, 24'hedc63a,
        24'h000000, 24'ha71bce, 24'h2ab5b6, 24'hd11eaa,
        24'h000000, 24'hf6f644, 24'h0a07bd, 24'hd5fbf9,
        24'h000000, 24'h2db8e0, 24'hd11eaa, 24'hcdf040,
        24'h000000, 24'h2db8e0, 24'hd11eaa, 24'hcdf040,
        24'h000000, 24'h2db8e0, 24'hd11eaa, 24'hcdf040,
        24'h000000, 24'h35e7bf, 24'h2db8e0, 24'h36e8e9,
        24'h000000, 24'hca1618, 24'hf6f644, 24'hffffff,
        24'h000000, 24'hca1618, 24'hf6f644, 24'hffffff,
        24'h000000, 24'hd31fd2, 24'hf4cdcf, 24'hf6f644,
        24'h000000, 24'hd31fd2, 24'hf4cdcf, 24'hf6f644,
        24'h000000, 24'hd31fd2, 24'hf4cdcf, 24'hf6f644,
        24'h000000, 24'hca1618, 24'hffffff, 24'hd31fd2,
        24'h000000, 24'h23ad24, 24'ha518a5, 24'hffffff,
        24'h000000, 24'h0a07bd, 24'h9f1114, 24'hc0c136,
        24'h000000, 24'h0a07bd, 24'hd11eaa, 24'hedc63a,
        24'h000000, 24'hcdf040, 24'ha71bce, 24'hedc63a,
        24'h000000, 24'ha71bce, 24'h2ab5b6, 24'hd11eaa,
        24'h000000, 24'hd11eaa, 24'h2db8e0, 24'hcdf040,
        24'h000000, 24'hd11eaa, 24'h2db8e0, 24'hcdf040,
        24'h000000, 24'hd11eaa, 24'h2db8e0, 24'hcdf040,
        24'h000000, 24'hd11eaa, 24'h2db8e0, 24'hcdf040,
        24'h000000, 24'h35e7bf, 24'h2db8e0, 24'hf6f644,
        24'h000000, 24'hca1618, 24'hf6f644, 24'hffffff,
        24'h000000, 24'hca1618, 24'hf6f644, 24'hffffff,
        24'h000000, 24'h2edf2d, 24'hf6f644, 24'hf5d0f5,
        24'h000000, 24'h2edf2d, 24'hf6f644, 24'hf5d0f5,
        24'h000000, 24'h2edf2d, 24'hf6f644, 24'hf5d0f5,
        24'h000000, 24'hd31fd2, 24'hffffff, 24'hf6f644,
        24'h000000, 24'h2edf2d, 24'ha518a5, 24'hffffff
    };

    function automatic logic [23:0] color_lookup(input logic [6:0] idx);
        return COLOR_TABLE[idx];
    endfunction

endpackage

### rtl/tvb_front.sv
// ----------------------------------------------------------------------------
// tvb_front
// Accepts command items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module tvb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2:0]         i_cmd,
    input  logic [15:0]        i_address,
    input  logic [7:0]         i_data,
    input  logic [15:0]        i_beam_pos,
    input  logic [7:0]         i_pixel_x,
    input  logic [7:0]         i_pixel_y,
    input  logic [1:0]         i_rom_region,
    input  tvb_pkg::t_back_stat i_stat,
    output logic               o_busy,
    output logic               o_valid,
    output tvb_pkg::t_item     o_item
);

    localparam int PW = $clog2(tvb_pkg::QUEUE_DEPTH);

    tvb_pkg::t_item r_queue [tvb_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [PW:0]    r_count;
    tvb_pkg::t_item w_item;
    logic           w_push, w_pop;

    always_comb begin
        w_item.address     = i_address;
        w_item.data        = i_data;
        w_item.beam_pos    = i_beam_pos;
        w_item.pixel_x     = i_pixel_x;
        w_item.pixel_y     = i_pixel_y;
        w_item.rom_region  = i_rom_region;
        case (i_cmd)
            tvb_pkg::CMD_READ:  w_item.kind = tvb_pkg::K_READ;
            tvb_pkg::CMD_WRITE: w_item.kind = tvb_pkg::K_WRITE;
            tvb_pkg::CMD_PIXEL: w_item.kind = tvb_pkg::K_PIXEL;
            tvb_pkg::CMD_LOAD:  w_item.kind = tvb_pkg::K_LOAD;
            tvb_pkg::CMD_SETIN: w_item.kind = tvb_pkg::K_SETIN;
            default:            w_item.kind = tvb_pkg::K_NONE;
        endcase
    end

    assign o_busy  = (r_count == (PW+1)'(tvb_pkg::QUEUE_DEPTH)) || i_stat.clearing;
    assign w_push  = i_start && !o_busy;
    assign w_pop   = i_stat.take;
    assign o_valid = (r_count != '0);
    assign o_item  = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_item;
        end
    end

endmodule

### rtl/tvb_back.sv
// ----------------------------------------------------------------------------
// tvb_back
// Carries out queued items: bus map, memories, tile compositing and results.
// ----------------------------------------------------------------------------
module tvb_back #(
    parameter int VISIBLE_LINES    = tvb_pkg::VISIBLE_LINES,
    parameter int CLOCKS_PER_FRAME = tvb_pkg::CLOCKS_PER_FRAME
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  tvb_pkg::t_item      i_item,
    input  logic [7:0]          i_dip_byte,
    output tvb_pkg::t_back_stat o_stat,
    output logic                o_done,
    output tvb_pkg::t_result    o_result
);

    localparam int VBLANK = CLOCKS_PER_FRAME * VISIBLE_LINES / 256;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_FETCH   = 3'b010,
        ST_PATTERN = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [12:0] r_clr;
    logic        r_clearing;
    tvb_pkg::t_item r_item;
    logic        r_page, r_bank;
    logic [7:0]  r_scroll, r_input;
    logic [7:0]  r_bg_code, r_fg_code;
    logic        r_done;
    tvb_pkg::t_result r_res, n_res;
    logic        w_take;

    logic [7:0] vram [tvb_pkg::VRAM_BYTES];
    logic [7:0] prom [tvb_pkg::PROGRAM_BYTES];
    logic [7:0] bgm  [tvb_pkg::GRAPHICS_BYTES];
    logic [7:0] fgm  [tvb_pkg::GRAPHICS_BYTES];
    logic [7:0] r_vram_a, r_vram_b, r_prom, r_bg_hi, r_bg_lo, r_fg_hi, r_fg_lo;

    logic        w_vram_we, w_prom_we, w_bg_we, w_fg_we;
    logic [12:0] w_vram_wa, w_vram_ra, w_vram_rb;
    logic [7:0]  w_vram_wd;
    logic [7:0]  w_bx;
    logic [11:0] w_bg_hi_a, w_bg_lo_a, w_fg_hi_a, w_fg_lo_a;
    logic [7:0]  w_pbx;
    logic [1:0]  w_pen, w_fpen;

    assign w_take          = (r_state == ST_IDLE) && !r_clearing && i_valid;
    assign o_stat.take     = w_take;
    assign o_stat.clearing = r_clearing;
    assign o_done          = r_done;
    assign o_result        = r_res;

    always_comb begin
        w_bx      = i_item.pixel_x + r_scroll;
        w_vram_ra = {r_page, i_item.address[11:0]};
        w_vram_rb = {r_page, 2'b00, i_item.pixel_y[7:3], i_item.pixel_x[7:3]};
        if (i_item.kind == tvb_pkg::K_PIXEL) begin
            w_vram_ra = {r_page, 2'b10, i_item.pixel_y[7:3], w_bx[7:3]};
        end
        w_bg_hi_a = {1'b1, r_vram_a, r_item.pixel_y[2:0]};
        w_bg_lo_a = {1'b0, r_vram_a, r_item.pixel_y[2:0]};
        w_fg_hi_a = {1'b1, r_vram_b, r_item.pixel_y[2:0]};
        w_fg_lo_a = {1'b0, r_vram_b, r_item.pixel_y[2:0]};
        w_vram_we = 1'b0;
        w_vram_wa = {r_page, i_item.address[11:0]};
        w_vram_wd = i_item.data;
        w_prom_we = 1'b0;
        w_bg_we   = 1'b0;
        w_fg_we   = 1'b0;
        if (r_clearing) begin
            w_vram_we = 1'b1;
            w_vram_wa = r_clr;
            w_vram_wd = '0;
        end else if (w_take) begin
            if (i_item.kind == tvb_pkg::K_WRITE && i_item.address[15:12] == 4'h4) begin
                w_vram_we = 1'b1;
            end
            if (i_item.kind == tvb_pkg::K_LOAD) begin
                w_prom_we = (i_item.rom_region == tvb_pkg::REGION_PROGRAM)
                            && (i_item.address[15:14] == 2'b00);
                w_bg_we   = (i_item.rom_region == tvb_pkg::REGION_BG)
                            && (i_item.address[15:12] == 4'h0);
                w_fg_we   = (i_item.rom_region == tvb_pkg::REGION_FG)
                            && (i_item.address[15:12] == 4'h0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vram_we) begin
            vram[w_vram_wa] <= w_vram_wd;
        end
        r_vram_a <= vram[w_vram_ra];
        r_vram_b <= vram[w_vram_rb];
    end

    always_ff @(posedge i_clk) begin
        if (w_prom_we) begin
            prom[i_item.address[13:0]] <= i_item.data;
        end
        r_prom <= prom[i_item.address[13:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_bg_we) begin
            bgm[i_item.address[11:0]] <= i_item.data;
        end
        r_bg_hi <= bgm[w_bg_hi_a];
        r_bg_lo <= bgm[w_bg_lo_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_fg_we) begin
            fgm[i_item.address[11:0]] <= i_item.data;
        end
        r_fg_hi <= fgm[w_fg_hi_a];
        r_fg_lo <= fgm[w_fg_lo_a];
    end

    always_comb begin
        n_state = r_state;
        n_res   = '0;
        w_pbx   = r_item.pixel_x + r_scroll;
        w_pen   = {r_bg_hi[w_pbx[2:0]], r_bg_lo[w_pbx[2:0]]};
        w_fpen  = {r_fg_hi[r_item.pixel_x[2:0]], r_fg_lo[r_item.pixel_x[2:0]]};
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (r_item.kind == tvb_pkg::K_PIXEL) begin
                    n_state = ST_PATTERN;
                end else begin
                    n_state = ST_IDLE;
                end
                if (r_item.kind == tvb_pkg::K_READ) begin
                    n_res.read_data = 8'hFF;
                    if (r_item.address < 16'h4000) begin
                        n_res.read_data = r_prom;
                    end else if (r_item.address < 16'h5000) begin
                        n_res.read_data = r_vram_a;
                    end else if (r_item.address inside {[16'h7000:16'h73FF]}) begin
                        n_res.read_data = r_input;
                    end else if (r_item.address inside {[16'h7800:16'h7BFF]}) begin
                        n_res.read_data = i_dip_byte
                            | (({1'b0, r_item.beam_pos} >= 17'(VBLANK)) ? 8'h00 : 8'h80);
                    end
                end
                if (r_item.kind == tvb_pkg::K_WRITE) begin
                    if (r_item.address inside {[16'h6000:16'h63FF]}) begin
                        n_res.sound_valid = 1'b1;
                        n_res.sound_data  = r_item.data;
                    end else if (r_item.address inside {[16'h6800:16'h6BFF]}) begin
                        n_res.sound_valid   = 1'b1;
                        n_res.sound_channel = 1'b1;
                        n_res.sound_data    = r_item.data;
                    end
                end
            end
            ST_PATTERN: begin
                n_state = ST_IDLE;
                if (w_fpen != 2'b00) begin
                    n_res.pixel_rgb = tvb_pkg::color_lookup(
                        {r_bank, 1'b1, r_fg_code[7:5], w_fpen});
                end else begin
                    n_res.pixel_rgb = tvb_pkg::color_lookup(
                        {r_bank, 1'b0, r_bg_code[7:5], w_pen});
                end
                n_res.screen_x = 8'(VISIBLE_LINES - 1) - r_item.pixel_y;
                n_res.screen_y = r_item.pixel_x;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_clr      <= '0;
            r_clearing <= 1'b1;
            r_page     <= 1'b0;
            r_bank     <= 1'b0;
            r_scroll   <= '0;
            r_input    <= 8'hFF;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            r_done <= ((r_state == ST_FETCH) && (r_item.kind != tvb_pkg::K_PIXEL))
                      || (r_state == ST_PATTERN);
            if (w_take && i_item.kind == tvb_pkg::K_WRITE) begin
                if (i_item.address inside {[16'h5000:16'h53FF]}) begin
                    r_page <= i_item.data[0];
                    r_bank <= i_item.data[1];
                end
                if (i_item.address inside {[16'h5800:16'h5BFF]}) begin
                    r_scroll <= i_item.data;
                end
            end
            if (w_take && i_item.kind == tvb_pkg::K_SETIN) begin
                r_input <= i_item.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
        if (r_state == ST_FETCH) begin
            r_bg_code <= r_vram_a;
            r_fg_code <= r_vram_b;
        end
        if (r_state != ST_IDLE) begin
            r_res <= n_res;
        end
    end

endmodule

### rtl/tile_video_board_bus_and_pixel.sv
// ----------------------------------------------------------------------------
// tile_video_board_bus_and_pixel
// Board memory map and two-layer tile video with an APB register port.
// ----------------------------------------------------------------------------
// An item waits in the queue until the back end is idle; the back end then registers the
// memory reads, and for a pixel the pattern reads after them, before it registers the result.
// The back end takes a new item only after it has finished the previous one.
// The result strobe is high for one cycle and the receiver cannot stall it.
// After reset all 8192 bytes of the video RAM are cleared with busy high.
module tile_video_board_bus_and_pixel #(
    parameter int VISIBLE_LINES    = tvb_pkg::VISIBLE_LINES,
    parameter int CLOCKS_PER_FRAME = tvb_pkg::CLOCKS_PER_FRAME
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_beam_pos,
    input  logic [7:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic [1:0]  i_rom_region,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic        o_sound_valid,
    output logic        o_sound_channel,
    output logic [7:0]  o_sound_data,
    output logic [23:0] o_pixel_rgb,
    output logic [7:0]  o_screen_x,
    output logic [7:0]  o_screen_y
);

    logic [7:0]          r_dip;
    tvb_pkg::t_back_stat w_stat;
    tvb_pkg::t_item      w_item;
    tvb_pkg::t_result    w_res;
    logic                w_valid;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tvb_pkg::REG_DIP_BYTE[0]) ? {24'd0, r_dip} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip <= 8'h60;
        end else if (psel && penable && pwrite && paddr[2] == tvb_pkg::REG_DIP_BYTE[0]) begin
            r_dip <= pwdata[7:0];
        end
    end

    tvb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_cmd         (i_cmd),
        .i_address     (i_address),
        .i_data        (i_data),
        .i_beam_pos    (i_beam_pos),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_rom_region  (i_rom_region),
        .i_stat        (w_stat),
        .o_busy        (busy),
        .o_valid       (w_valid),
        .o_item        (w_item)
    );

    tvb_back #(
        .VISIBLE_LINES    (VISIBLE_LINES),
        .CLOCKS_PER_FRAME (CLOCKS_PER_FRAME)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .i_dip_byte (r_dip),
        .o_stat     (w_stat),
        .o_done     (o_done),
        .o_result   (w_res)
    );

    assign o_read_data     = w_res.read_data;
    assign o_sound_valid   = w_res.sound_valid;
    assign o_sound_channel = w_res.sound_channel;
    assign o_sound_data    = w_res.sound_data;
    assign o_pixel_rgb     = w_res.pixel_rgb;
    assign o_screen_x      = w_res.screen_x;
    assign o_screen_y      = w_res.screen_y;

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clearing |-> busy) else $error("busy low while video RAM is cleared");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clearing |-> !o_done) else $error("result given during clearing");

    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("results on consecutive cycles");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.take |-> w_valid) else $error("item taken from an empty queue");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the board bus and tile video block. Commands are
// driven in random bursts, each accepted item updates a local model of the
// memory map and video, and every result strobe is checked against the
// oldest predicted result.
// ----------------------------------------------------------------------------
class tvb_scoreboard;

    logic [7:0]  vram [8192];
    logic [7:0]  prog [16384];
    logic [7:0]  bg_gfx [4096];
    logic [7:0]  fg_gfx [4096];
    bit          prog_ok [16384];
    logic        page;
    logic        bank;
    logic [7:0]  scroll;
    logic [7:0]  in_byte;
    logic [7:0]  dip;
    tvb_pkg::t_result pending [$];
    int          mismatches;
    int          checked;

    function void clear();
        foreach (vram[i]) vram[i] = 8'h00;
        foreach (prog[i]) begin
            prog[i] = 8'h00;
            prog_ok[i] = 1'b0;
        end
        foreach (bg_gfx[i]) bg_gfx[i] = 8'h00;
        foreach (fg_gfx[i]) fg_gfx[i] = 8'h00;
        page = 0;
        bank = 0;
        scroll = 8'h00;
        in_byte = 8'hFF;
        dip = 8'h60;
        mismatches = 0;
        checked = 0;
    endfunction

    function logic [1:0] tile_pen(bit fg, logic [7:0] code, logic [7:0] col, logic [7:0] row);
        logic [10:0] ln;
        logic [7:0]  hi;
        logic [7:0]  lo;
        ln = {code, row[2:0]};
        hi = fg ? fg_gfx[{1'b1, ln}] : bg_gfx[{1'b1, ln}];
        lo = fg ? fg_gfx[{1'b0, ln}] : bg_gfx[{1'b0, ln}];
        return {hi[col[2:0]], lo[col[2:0]]};
    endfunction

    function void note_item(logic [2:0] cmd, logic [15:0] a, logic [7:0] d, logic [15:0] fc,
                            logic [7:0] px, logic [7:0] py, logic [1:0] rg);
        tvb_pkg::t_result r;
        logic [7:0]  bx;
        logic [7:0]  bcode;
        logic [7:0]  fcode;
        logic [1:0]  pen;
        logic [6:0]  idx;
        r = '0;
        case (cmd)
            tvb_pkg::CMD_READ: begin
                if (a < 16'h4000) r.read_data = prog[a[13:0]];
                else if (a < 16'h5000) r.read_data = vram[{page, a[11:0]}];
                else if (a >= 16'h7000 && a < 16'h7400) r.read_data = in_byte;
                else if (a >= 16'h7800 && a < 16'h7C00)
                    r.read_data = dip | ((fc >= 16'd36608) ? 8'h00 : 8'h80);
                else r.read_data = 8'hFF;
            end
            tvb_pkg::CMD_WRITE: begin
                if (a >= 16'h4000 && a < 16'h5000) vram[{page, a[11:0]}] = d;
                else if (a >= 16'h5000 && a < 16'h5400) begin
                    page = d[0];
                    bank = d[1];
                end else if (a >= 16'h5800 && a < 16'h5C00) scroll = d;
                else if (a >= 16'h6000 && a < 16'h6400) begin
                    r.sound_valid = 1;
                    r.sound_data = d;
                end else if (a >= 16'h6800 && a < 16'h6C00) begin
                    r.sound_valid = 1;
                    r.sound_channel = 1;
                    r.sound_data = d;
                end
            end
            tvb_pkg::CMD_PIXEL: begin
                bx = px + scroll;
                bcode = vram[{page, 2'b10, py[7:3], bx[7:3]}];
                pen = tile_pen(1'b0, bcode, bx, py);
                idx = {bank, 1'b0, bcode[7:5], pen};
                r.pixel_rgb = tvb_pkg::COLOR_TABLE[idx];
                fcode = vram[{page, 2'b00, py[7:3], px[7:3]}];
                pen = tile_pen(1'b1, fcode, px, py);
                if (pen != 0) begin
                    idx = {bank, 1'b1, fcode[7:5], pen};
                    r.pixel_rgb = tvb_pkg::COLOR_TABLE[idx];
                end
                r.screen_x = 8'd207 - py;
                r.screen_y = px;
            end
            tvb_pkg::CMD_LOAD: begin
                if (rg == tvb_pkg::REGION_PROGRAM && a < 16384) begin
                    prog[a[13:0]] = d;
                    prog_ok[a[13:0]] = 1'b1;
                end else if (rg == tvb_pkg::REGION_BG && a < 4096) bg_gfx[a[11:0]] = d;
                else if (rg == tvb_pkg::REGION_FG && a < 4096) fg_gfx[a[11:0]] = d;
            end
            tvb_pkg::CMD_SETIN: in_byte = d;
            default: ;
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(tvb_pkg::t_result got);
        tvb_pkg::t_result want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: result %0d expected rd=%h sv=%b sc=%b sd=%h rgb=%h x=%h y=%h",
                         checked, want.read_data, want.sound_valid, want.sound_channel,
                         want.sound_data, want.pixel_rgb, want.screen_x, want.screen_y);
                $display("       got rd=%h sv=%b sc=%b sd=%h rgb=%h x=%h y=%h",
                         got.read_data, got.sound_valid, got.sound_channel, got.sound_data,
                         got.pixel_rgb, got.screen_x, got.screen_y);
            end
        end
    endfunction

endclass

module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [2:0]  i_cmd;
    logic [15:0] i_address;
    logic [7:0]  i_data;
    logic [15:0] i_beam_pos;
    logic [7:0]  i_pixel_x;
    logic [7:0]  i_pixel_y;
    logic [1:0]  i_rom_region;
    logic        o_done;
    logic [7:0]  o_read_data;
    logic        o_sound_valid;
    logic        o_sound_channel;
    logic [7:0]  o_sound_data;
    logic [23:0] o_pixel_rgb;
    logic [7:0]  o_screen_x;
    logic [7:0]  o_screen_y;

    tvb_scoreboard board;
    int          idle_cycles;
    int          burst_left;
    int          sent;
    int          cmd_count [8];

    tile_video_board_bus_and_pixel u_top (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (o_done) board.check_result('{o_read_data, o_sound_valid, o_sound_channel,
                                         o_sound_data, o_pixel_rgb, o_screen_x, o_screen_y});
        if (start && !busy) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 50000) begin
            $display("tile_video_board_bus_and_pixel test failed");
            $finish;
        end
    end

    task automatic write_dip(logic [7:0] v);
        psel <= 1;
        pwrite <= 1;
        paddr <= {tvb_pkg::REG_DIP_BYTE[0], 2'b00};
        pwdata <= {24'h0, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        board.dip = v;
    endtask

    task automatic send(logic [2:0] cmd, logic [15:0] a, logic [7:0] d, logic [15:0] fc,
                        logic [7:0] px, logic [7:0] py, logic [1:0] rg);
        if (burst_left == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start <= 1;
        i_cmd <= cmd;
        i_address <= a;
        i_data <= d;
        i_beam_pos <= fc;
        i_pixel_x <= px;
        i_pixel_y <= py;
        i_rom_region <= rg;
        do @(posedge i_clk); while (busy);
        board.note_item(cmd, a, d, fc, px, py, rg);
        cmd_count[cmd]++;
        sent++;
    endtask

    task automatic drain();
        start <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic random_item();
        int          pick;
        logic [15:0] a;
        logic [7:0]  d;
        pick = $urandom_range(0, 99);
        d = 8'($urandom);
        if (pick < 15) begin
            a = 16'($urandom_range(0, 16383));
            while (!board.prog_ok[a[13:0]]) a = 16'($urandom_range(0, 16383));
            if ($urandom_range(0, 3) == 0) a = 16'($urandom_range(16'h4000, 16'hFFFF));
            send(tvb_pkg::CMD_READ, a, d, 16'($urandom), 8'($urandom), 8'($urandom),
                 2'($urandom));
        end else if (pick < 45) begin
            case ($urandom_range(0, 6))
                0: a = 16'($urandom_range(16'h5000, 16'h53FF));
                1: a = 16'($urandom_range(16'h5800, 16'h5BFF));
                2: a = 16'($urandom_range(16'h6000, 16'h63FF));
                3: a = 16'($urandom_range(16'h6800, 16'h6BFF));
                4: a = 16'($urandom);
                default: a = 16'($urandom_range(16'h4000, 16'h4FFF));
            endcase
            if (a >= 16'h4000 && a < 16'h5000) d = d & 8'hE1;
            send(tvb_pkg::CMD_WRITE, a, d, 16'($urandom), 8'($urandom), 8'($urandom),
                 2'($urandom));
        end else if (pick < 80) begin
            send(tvb_pkg::CMD_PIXEL, 16'($urandom), d, 16'($urandom), 8'($urandom),
                 ($urandom_range(0, 9) == 0) ? 8'($urandom_range(208, 255))
                                             : 8'($urandom_range(0, 207)),
                 2'($urandom));
        end else if (pick < 93) begin
            send(tvb_pkg::CMD_LOAD,
                 ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095)),
                 d, 16'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
        end else if (pick < 97) begin
            send(tvb_pkg::CMD_SETIN, 16'($urandom), d, 16'($urandom), 8'($urandom),
                 8'($urandom), 2'($urandom));
        end else begin
            send(3'($urandom_range(5, 7)), 16'($urandom), d, 16'($urandom), 8'($urandom),
                 8'($urandom), 2'($urandom));
        end
    endtask

    initial begin
        logic [15:0] ga;
        board = new();
        board.clear();
        sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        foreach (cmd_count[i]) cmd_count[i] = 0;
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        start = 0;
        i_cmd = '0;
        i_address = '0;
        i_data = '0;
        i_beam_pos = '0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        i_rom_region = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Tile codes written by the random items keep bits 4:1 clear, so only their patterns are loaded.
        for (int c = 0; c < 256; c++) begin
            if ((c & 8'h1E) == 0) begin
                for (int r = 0; r < 8; r++) begin
                    for (int p = 0; p < 2; p++) begin
                        ga = 16'((p * 2048) + (c * 8) + r);
                        send(tvb_pkg::CMD_LOAD, ga, 8'($urandom), '0, '0, '0,
                             tvb_pkg::REGION_BG);
                        send(tvb_pkg::CMD_LOAD, ga, 8'($urandom), '0, '0, '0,
                             tvb_pkg::REGION_FG);
                    end
                end
            end
        end
        for (int i = 0; i < 64; i++) begin
            send(tvb_pkg::CMD_LOAD, 16'(i), 8'($urandom), '0, '0, '0,
                 tvb_pkg::REGION_PROGRAM);
            send(tvb_pkg::CMD_LOAD, 16'(16383 - i), 8'($urandom), '0, '0, '0,
                 tvb_pkg::REGION_PROGRAM);
        end

        send(tvb_pkg::CMD_READ, 16'h0000, '0, '0, '0, '0, '0);
        send(tvb_pkg::CMD_READ, 16'h3FFF, '0, '0, '0, '0, '0);
        send(tvb_pkg::CMD_READ, 16'h4000, '0, '0, '0, '0, '0);
        send(tvb_pkg::CMD_READ, 16'h7000, '0, '0, '0, '0, '0);
        send(tvb_pkg::CMD_READ, 16'h7800, '0, 16'd36607, '0, '0, '0);
        send(tvb_pkg::CMD_READ, 16'h7BFF, '0, 16'd36608, '0, '0, '0);
        send(tvb_pkg::CMD_READ, 16'hFFFF, '0, 16'hFFFF, '0, '0, '0);
        send(tvb_pkg::CMD_WRITE, 16'h4FFF, 8'hFF, '0, '0, '0, '0);
        send(tvb_pkg::CMD_WRITE, 16'h5000, 8'hFF, '0, '0, '0, '0);
        send(tvb_pkg::CMD_WRITE, 16'h4FFF, 8'hA5, '0, '0, '0, '0);
        send(tvb_pkg::CMD_READ, 16'h4FFF, '0, '0, '0, '0, '0);
        send(tvb_pkg::CMD_WRITE, 16'h5BFF, 8'hFF, '0, '0, '0, '0);
        send(tvb_pkg::CMD_WRITE, 16'h6000, 8'h00, '0, '0, '0, '0);
        send(tvb_pkg::CMD_WRITE, 16'h6BFF, 8'hFF, '0, '0, '0, '0);
        send(tvb_pkg::CMD_PIXEL, '0, '0, '0, 8'd0, 8'd0, '0);
        send(tvb_pkg::CMD_PIXEL, '0, '0, '0, 8'd255, 8'd207, '0);
        send(tvb_pkg::CMD_PIXEL, '0, '0, '0, 8'd255, 8'd255, '0);
        send(tvb_pkg::CMD_LOAD, 16'hFFFF, 8'h12, '0, '0, '0, 2'd3);
        send(tvb_pkg::CMD_SETIN, '0, 8'h00, '0, '0, '0, '0);
        send(tvb_pkg::CMD_READ, 16'h73FF, '0, '0, '0, '0, '0);
        send(3'd7, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 2'd3);

        for (int phase = 0; phase < 4; phase++) begin
            drain();
            write_dip((phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom));
            for (int i = 0; i < 300; i++) random_item();
        end

        drain();
        $display("Checked %0d results over %0d items: %0d reads and %0d writes,",
                 board.checked, sent, cmd_count[0], cmd_count[1]);
        $display("%0d pixels and %0d loads, across four DIP byte settings.",
                 cmd_count[2], cmd_count[3]);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("tile_video_board_bus_and_pixel test passed");
        end else begin
            $display("tile_video_board_bus_and_pixel test failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tvb_pkg.sv
rtl/tvb_front.sv
rtl/tvb_back.sv
rtl/tile_video_board_bus_and_pixel.sv
tb/tb_top.sv
